[sv/efp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_pkg
// shared types and constants of the escape-time fractal pixel unit
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_W    = COORD_W - 4;
  localparam int PIX_W     = 12;
  localparam int ITER_W    = 16;
  localparam int PCNT_W    = 3;
  localparam int PAL_W     = 48;
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int T_W       = 17;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd256;
  localparam logic [T_W-1:0]    T_ONE        = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_COUNT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_LO    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_HI    = 4'd7;

  localparam logic MODE_MANDEL = 1'b0;
  localparam logic MODE_JULIA  = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [COORD_W-1:0]  origin_x;
    logic signed [COORD_W-1:0]  origin_y;
    logic signed [COORD_W-1:0]  step_x;
    logic signed [COORD_W-1:0]  step_y;
    logic signed [COORD_W-1:0]  seed_x;
    logic signed [COORD_W-1:0]  seed_y;
    logic [ITER_W-1:0]          max_iter;
    logic [PCNT_W-1:0]          palette_count;
    logic [PAL_W-1:0]           palette_lo;
    logic [PAL_W-1:0]           palette_hi;
  } cfg_t;

  // start value and additive constant of one pixel
  typedef struct packed {
    logic signed [COORD_W-1:0] zx;
    logic signed [COORD_W-1:0] zy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } point_t;

  typedef enum logic [1:0] {IT_IDLE, IT_MUL, IT_ADD, IT_DONE} iter_state_t;
  typedef enum logic [1:0] {SH_IDLE, SH_DIV, SH_BLEND, SH_OUT} shade_state_t;

endpackage

[sv/efp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_in_if / efp_out_if
// valid/ready channels of the pixel unit
// ----------------------------------------------------------------------------
interface efp_in_if;
  logic                        valid;
  logic                        ready;
  logic [efp_pkg::PIX_W-1:0]   pixel_x;
  logic [efp_pkg::PIX_W-1:0]   pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface efp_out_if;
  logic                        valid;
  logic                        ready;
  logic [efp_pkg::CHAN_W-1:0]  red;
  logic [efp_pkg::CHAN_W-1:0]  green;
  logic [efp_pkg::CHAN_W-1:0]  blue;
  logic [efp_pkg::ITER_W-1:0]  escape_count;
  modport source (output valid, output red, output green, output blue,
                  output escape_count, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input escape_count, output ready);
endinterface

[sv/efp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_fifo
// two-entry queue of pixel points between front and iteration engine
// ----------------------------------------------------------------------------
module efp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  efp_pkg::point_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output efp_pkg::point_t pop_data
);

  efp_pkg::point_t                 mem_r [efp_pkg::QUEUE_DEPTH];
  logic [efp_pkg::QUEUE_AW-1:0]    wptr_r, rptr_r;
  logic [efp_pkg::QUEUE_AW:0]      cnt_r, cnt_nxt;
  logic                            push, pop;

  assign push_ready = (cnt_r != (efp_pkg::QUEUE_AW+1)'(efp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (efp_pkg::QUEUE_AW+1)'(efp_pkg::QUEUE_DEPTH))
    else $error("queue overfilled");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

[sv/efp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_front
// maps a pixel to its point and picks start value and constant by mode
// ----------------------------------------------------------------------------
module efp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  efp_in_if.sink                    in_bus,
  input  efp_pkg::cfg_t             cfg,
  output logic                      pt_valid,
  input  logic                      pt_ready,
  output efp_pkg::point_t           pt_data
);

  logic [efp_pkg::COORD_W-1:0] prod_x, prod_y;
  logic signed [efp_pkg::COORD_W-1:0] px, py;
  efp_pkg::point_t pt;

  // low bits of pixel * step are the same signed or unsigned
  assign prod_x = efp_pkg::COORD_W'(cfg.step_x * {{(efp_pkg::COORD_W-efp_pkg::PIX_W){1'b0}},
                                                  in_bus.pixel_x});
  assign prod_y = efp_pkg::COORD_W'(cfg.step_y * {{(efp_pkg::COORD_W-efp_pkg::PIX_W){1'b0}},
                                                  in_bus.pixel_y});
  assign px = cfg.origin_x + $signed(prod_x);
  assign py = cfg.origin_y + $signed(prod_y);

  always_comb begin
    if (cfg.mode == efp_pkg::MODE_JULIA) begin
      pt.zx = px;         pt.zy = py;
      pt.cx = cfg.seed_x; pt.cy = cfg.seed_y;
    end else begin
      pt.zx = cfg.seed_x; pt.zy = cfg.seed_y;
      pt.cx = px;         pt.cy = py;
    end
  end

  efp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_bus.valid),
    .push_ready(in_bus.ready),
    .push_data (pt),
    .pop_valid (pt_valid),
    .pop_ready (pt_ready),
    .pop_data  (pt_data)
  );

endmodule

[sv/efp_iter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_iter
// escape-time engine: squares in the multiply state, update and test in the next
// ----------------------------------------------------------------------------
module efp_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [efp_pkg::ITER_W-1:0]  limit,
  input  logic                        pt_valid,
  output logic                        pt_ready,
  input  efp_pkg::point_t             pt_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [efp_pkg::ITER_W-1:0]  res_cnt
);

  localparam int PW = 2 * efp_pkg::COORD_W;
  localparam int SW = efp_pkg::COORD_W + 8;
  localparam logic [PW:0] FOUR = (PW+1)'(4) << (2 * efp_pkg::FRAC_W);

  efp_pkg::iter_state_t state_r, state_nxt;
  logic signed [efp_pkg::COORD_W-1:0] zx_r, zy_r, cx_r, cy_r, zx_nxt, zy_nxt;
  logic signed [PW-1:0] pxx_r, pyy_r, pxy_r, dxy;
  logic [efp_pkg::ITER_W-1:0] i_r, i_nxt, cnt_r, cnt_nxt;
  logic first_r, first_nxt;
  logic signed [SW-1:0] nx_w, ny_w;
  logic mag_gt, esc_mag, at_lim, out_rng;

  assign dxy  = pxx_r - pyy_r;
  assign nx_w = $signed({{(SW-PW+efp_pkg::FRAC_W){dxy[PW-1]}}, dxy[PW-1:efp_pkg::FRAC_W]})
              + $signed({{(SW-efp_pkg::COORD_W){cx_r[efp_pkg::COORD_W-1]}}, cx_r});
  assign ny_w = $signed({{(SW-PW+efp_pkg::FRAC_W-1){pxy_r[PW-1]}},
                         pxy_r[PW-1:efp_pkg::FRAC_W-1]})
              + $signed({{(SW-efp_pkg::COORD_W){cy_r[efp_pkg::COORD_W-1]}}, cy_r});
  // in range when the wide sum equals the sign extension of its low word
  assign out_rng = (nx_w != SW'($signed(nx_w[efp_pkg::COORD_W-1:0])))
                || (ny_w != SW'($signed(ny_w[efp_pkg::COORD_W-1:0])));
  assign mag_gt  = ({1'b0, pxx_r} + {1'b0, pyy_r}) > FOUR;
  assign esc_mag = !first_r && mag_gt;
  assign at_lim  = (i_r == limit);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efp_pkg::IT_IDLE: if (pt_valid) state_nxt = efp_pkg::IT_MUL;
      efp_pkg::IT_MUL:  state_nxt = efp_pkg::IT_ADD;
      efp_pkg::IT_ADD:  state_nxt = (esc_mag || at_lim || out_rng) ? efp_pkg::IT_DONE
                                                                   : efp_pkg::IT_MUL;
      efp_pkg::IT_DONE: if (res_ready) state_nxt = efp_pkg::IT_IDLE;
      default:          state_nxt = efp_pkg::IT_IDLE;
    endcase
  end

  always_comb begin
    pt_ready  = (state_r == efp_pkg::IT_IDLE);
    res_valid = (state_r == efp_pkg::IT_DONE);
    res_cnt   = cnt_r;
  end

  always_comb begin
    zx_nxt = zx_r; zy_nxt = zy_r; i_nxt = i_r; first_nxt = first_r; cnt_nxt = cnt_r;
    if (state_r == efp_pkg::IT_IDLE) begin
      zx_nxt = pt_data.zx; zy_nxt = pt_data.zy; i_nxt = '0; first_nxt = 1'b1;
    end else if (state_r == efp_pkg::IT_ADD) begin
      if (esc_mag)               cnt_nxt = i_r - 1'b1;
      else if (at_lim || out_rng) cnt_nxt = i_r;
      else begin
        zx_nxt = nx_w[efp_pkg::COORD_W-1:0];
        zy_nxt = ny_w[efp_pkg::COORD_W-1:0];
        i_nxt  = i_r + 1'b1;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= efp_pkg::IT_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    zx_r <= zx_nxt; zy_r <= zy_nxt; i_r <= i_nxt; first_r <= first_nxt; cnt_r <= cnt_nxt;
    if (state_r == efp_pkg::IT_IDLE) begin
      cx_r <= pt_data.cx; cy_r <= pt_data.cy;
    end
    if (state_r == efp_pkg::IT_MUL) begin
      pxx_r <= zx_r * zx_r;
      pyy_r <= zy_r * zy_r;
      pxy_r <= zx_r * zy_r;
    end
  end

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == efp_pkg::IT_ADD && first_r) |-> i_r == '0)
    else $error("first test with nonzero iteration index");

endmodule

[sv/efp_shade.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_shade
// blend parameter by restoring division, then de casteljau palette blend
// ----------------------------------------------------------------------------
module efp_shade #(
  parameter int PALETTE_SLOTS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  efp_pkg::cfg_t               cfg,
  input  logic                        res_valid,
  output logic                        res_ready,
  input  logic [efp_pkg::ITER_W-1:0]  res_cnt,
  efp_out_if.source                   out_bus
);

  localparam int LVL_W = $clog2(PALETTE_SLOTS);
  localparam int NUM_W = 2 * efp_pkg::ITER_W;
  localparam int CW    = efp_pkg::COLOR_W;

  efp_pkg::shade_state_t state_r, state_nxt;
  logic [NUM_W-1:0]            num_r;
  logic [efp_pkg::ITER_W:0]    rem_r, rem_s;
  logic [$clog2(NUM_W)-1:0]    ctr_r;
  logic [efp_pkg::T_W-1:0]     t_r;
  logic [efp_pkg::ITER_W-1:0]  cnt_r;
  logic [LVL_W-1:0]            lvl_r;
  logic                        blank_r;
  logic [CW-1:0]               pts_r   [PALETTE_SLOTS][3];
  logic [CW-1:0]               pts_ld  [PALETTE_SLOTS][3];
  logic [CW-1:0]               pts_lrp [PALETTE_SLOTS][3];
  logic [efp_pkg::CHAN_W-1:0]  rgb_r [3];
  logic                        q_bit, accept, div_done;
  int                          n_use;

  assign accept   = res_valid && res_ready;
  assign rem_s    = {rem_r[efp_pkg::ITER_W-1:0], num_r[NUM_W-1]};
  assign q_bit    = (rem_s >= {1'b0, cfg.max_iter});
  assign div_done = (ctr_r == '0);
  assign n_use    = (int'(cfg.palette_count) > PALETTE_SLOTS) ? PALETTE_SLOTS
                                                              : int'(cfg.palette_count);

  // palette load: slots past the two packed registers are black
  always_comb begin
    for (int k = 0; k < PALETTE_SLOTS; k++) begin
      for (int c = 0; c < 3; c++) begin
        if (k < 2)
          pts_ld[k][c] = {cfg.palette_lo[CW*k + 16 - 8*c +: 8], 16'b0};
        else if (k < 4)
          pts_ld[k][c] = {cfg.palette_hi[CW*(k-2) + 16 - 8*c +: 8], 16'b0};
        else
          pts_ld[k][c] = '0;
      end
    end
  end

  // one de casteljau level, all points in parallel
  always_comb begin
    logic signed [CW:0]   diff;
    logic signed [CW+efp_pkg::T_W+1:0] prod;
    diff = '0;
    prod = '0;
    for (int k = 0; k < PALETTE_SLOTS; k++) begin
      for (int c = 0; c < 3; c++) begin
        if (k + 1 < PALETTE_SLOTS && k < int'(lvl_r)) begin
          diff = $signed({1'b0, pts_r[k+1][c]}) - $signed({1'b0, pts_r[k][c]});
          prod = diff * $signed({1'b0, t_r});
          pts_lrp[k][c] = pts_r[k][c] + prod[CW+15:16];
        end else begin
          pts_lrp[k][c] = pts_r[k][c];
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efp_pkg::SH_IDLE:  if (res_valid) state_nxt = (cfg.max_iter == '0) ? efp_pkg::SH_BLEND
                                                                          : efp_pkg::SH_DIV;
      efp_pkg::SH_DIV:   if (div_done) state_nxt = efp_pkg::SH_BLEND;
      efp_pkg::SH_BLEND: if (lvl_r == '0) state_nxt = efp_pkg::SH_OUT;
      efp_pkg::SH_OUT:   if (out_bus.ready) state_nxt = efp_pkg::SH_IDLE;
      default:           state_nxt = efp_pkg::SH_IDLE;
    endcase
  end

  always_comb begin
    res_ready            = (state_r == efp_pkg::SH_IDLE);
    out_bus.valid        = (state_r == efp_pkg::SH_OUT);
    out_bus.red          = rgb_r[0];
    out_bus.green        = rgb_r[1];
    out_bus.blue         = rgb_r[2];
    out_bus.escape_count = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= efp_pkg::SH_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r   <= res_cnt;
      num_r   <= {res_cnt, {efp_pkg::ITER_W{1'b0}}};
      rem_r   <= '0;
      ctr_r   <= '1;
      t_r     <= efp_pkg::T_ONE;
      blank_r <= (n_use < 2);
      lvl_r   <= (n_use < 2) ? '0 : LVL_W'(n_use - 1);
      pts_r   <= pts_ld;
    end else if (state_r == efp_pkg::SH_DIV) begin
      rem_r <= q_bit ? rem_s - {1'b0, cfg.max_iter} : rem_s;
      num_r <= {num_r[NUM_W-2:0], q_bit};
      ctr_r <= ctr_r - 1'b1;
      if (div_done) t_r <= {num_r[efp_pkg::T_W-2:0], q_bit};
    end else if (state_r == efp_pkg::SH_BLEND) begin
      pts_r <= pts_lrp;
      if (lvl_r != '0) lvl_r <= lvl_r - 1'b1;
      else begin
        for (int c = 0; c < 3; c++)
          rgb_r[c] <= blank_r ? '0 : pts_r[0][c][CW-1:16];
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != efp_pkg::SH_IDLE) |-> !res_ready)
    else $error("result taken while shading");

endmodule

[sv/escape_time_fractal_pixel_unit.sv]
`timescale 1ns / 1ps
// flow: the queue, then the escape engine (a multiply and an add state per iteration),
//   then restoring division, the palette blend levels and the output register
// throughput: the escape engine takes a new pixel only when idle, once the shading stage
//   has taken its last result; the shading stage likewise takes one result at a time
// reset: synchronous active low, clears queue and state machines; max_iter comes up as 256,
//   the other registers as 0
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit
// mandelbrot / julia escape-time pixel colouring with bezier palette blend
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_unit #(
  parameter int PALETTE_SLOTS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  efp_in_if.sink                          in_bus,
  efp_out_if.source                       out_bus,
  input  logic                            cfg_we,
  input  logic [efp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [efp_pkg::CFG_DAT_W-1:0]   cfg_data
);

  // configuration registers, to be written only while the unit is idle; the block itself does not enforce it
  efp_pkg::cfg_t cfg_r;

  // front to engine
  logic            pt_valid, pt_ready;
  efp_pkg::point_t pt_data;

  // engine to shading
  logic                       res_valid, res_ready;
  logic [efp_pkg::ITER_W-1:0] res_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= efp_pkg::MODE_MANDEL;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.step_x        <= '0;
      cfg_r.step_y        <= '0;
      cfg_r.seed_x        <= '0;
      cfg_r.seed_y        <= '0;
      cfg_r.max_iter      <= efp_pkg::MAX_ITER_RST;
      cfg_r.palette_count <= '0;
      cfg_r.palette_lo    <= '0;
      cfg_r.palette_hi    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efp_pkg::REG_MODE:      cfg_r.mode <= cfg_data[0];
        efp_pkg::REG_ORIGIN: begin
          cfg_r.origin_x <= cfg_data[31:0];
          cfg_r.origin_y <= cfg_data[63:32];
        end
        efp_pkg::REG_STEP: begin
          cfg_r.step_x <= cfg_data[31:0];
          cfg_r.step_y <= cfg_data[63:32];
        end
        efp_pkg::REG_SEED: begin
          cfg_r.seed_x <= cfg_data[31:0];
          cfg_r.seed_y <= cfg_data[63:32];
        end
        efp_pkg::REG_MAX_ITER:  cfg_r.max_iter      <= cfg_data[efp_pkg::ITER_W-1:0];
        efp_pkg::REG_PAL_COUNT: cfg_r.palette_count <= cfg_data[efp_pkg::PCNT_W-1:0];
        efp_pkg::REG_PAL_LO:    cfg_r.palette_lo    <= cfg_data[efp_pkg::PAL_W-1:0];
        efp_pkg::REG_PAL_HI:    cfg_r.palette_hi    <= cfg_data[efp_pkg::PAL_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // front: point mapping, mode select and two-entry queue
  efp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg     (cfg_r),
    .pt_valid(pt_valid),
    .pt_ready(pt_ready),
    .pt_data (pt_data)
  );

  // back: escape-time iteration
  efp_iter u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (cfg_r.max_iter),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .pt_data  (pt_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_cnt  (res_cnt)
  );

  // back: blend parameter, palette blend and output register
  efp_shade #(.PALETTE_SLOTS(PALETTE_SLOTS)) u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_cnt  (res_cnt),
    .out_bus  (out_bus)
  );

endmodule

[test/tb_escape_time_fractal_pixel_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_pixel_unit
// self-checking bench for the mandelbrot / julia pixel colouring unit
// ----------------------------------------------------------------------------
// A directed table covers reset state, max_iter zero, palette clamping, point
// wrap, an ignored register index and a full-depth max_iter setting. Random
// phases then reprogram every register and stream pixels through views of the
// set, with bursty input and a stalling result side. Each result beat is checked
// against a typed expectation if given, else a bit-exact fixed-point model here.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_pixel_unit;

  localparam int  N_RANDOM  = 700;
  localparam int  N_PHASES  = 10;
  localparam int  SETTLE    = 60;
  localparam longint LIMIT  = 10000000;
  // write to an index past the register list, must be ignored
  localparam logic [efp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd15;
  localparam logic [31:0] Q_ONE = 32'h1000_0000;

  typedef struct packed {
    logic [efp_pkg::CHAN_W-1:0] red;
    logic [efp_pkg::CHAN_W-1:0] green;
    logic [efp_pkg::CHAN_W-1:0] blue;
    logic [efp_pkg::ITER_W-1:0] escape_count;
  } shade_t;

  // directed row: optional register write, then one pixel
  typedef struct {
    logic                          do_write;
    logic [efp_pkg::CFG_IDX_W-1:0] idx;
    logic [efp_pkg::CFG_DAT_W-1:0] data;
    logic [efp_pkg::PIX_W-1:0]     px;
    logic [efp_pkg::PIX_W-1:0]     py;
    logic                          known;
    shade_t                        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [efp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [efp_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  efp_in_if  in_if();
  efp_out_if out_if();

  escape_time_fractal_pixel_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_if.sink), .out_bus(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // register mirror
  logic                       m_mode;
  logic [63:0]                m_origin, m_step, m_seed;
  logic [efp_pkg::ITER_W-1:0] m_max_iter;
  logic [efp_pkg::PCNT_W-1:0] m_pal_count;
  logic [efp_pkg::PAL_W-1:0]  m_pal_lo, m_pal_hi;

  shade_t pixel_due[$];
  int     bad_pixels = 0;
  int     pixels_sent = 0;
  int     pixels_seen = 0;
  int     julia_pixels = 0;
  int     escaped_pixels = 0;
  longint cycle_count = 0;
  int     burst_left = 0;

  // escape iteration count of one start point and constant
  function automatic int escape_iters(longint zx, longint zy, longint cx, longint cy,
                                      int limit);
    longint nx, ny;
    logic [63:0] mag;
    for (int i = 0; i < limit; i++) begin
      nx = ((zx * zx - zy * zy) >>> efp_pkg::FRAC_W) + cx;
      ny = ((zx * zy) >>> (efp_pkg::FRAC_W - 1)) + cy;
      // leaving q4.28 means magnitude 8 or more
      if (nx < -(64'sd1 <<< 31) || nx >= (64'sd1 <<< 31) ||
          ny < -(64'sd1 <<< 31) || ny >= (64'sd1 <<< 31))
        return i;
      // both squares can reach 2^62, so the sum is taken unsigned
      mag = $unsigned(nx * nx) + $unsigned(ny * ny);
      if (mag > (64'd4 << (2 * efp_pkg::FRAC_W)))
        return i;
      zx = nx;
      zy = ny;
    end
    return limit;
  endfunction

  // full pixel prediction from the mirrored registers
  function automatic shade_t shade_pixel(logic [efp_pkg::PIX_W-1:0] px,
                                         logic [efp_pkg::PIX_W-1:0] py);
    longint ptx, pty, sx, sy, t;
    longint pts[4][3];
    logic [31:0] w;
    logic [23:0] col;
    int cnt, n;
    shade_t r;
    w = 32'($signed(m_origin[31:0]) + longint'(px) * longint'($signed(m_step[31:0])));
    ptx = longint'($signed(w));
    w = 32'($signed(m_origin[63:32]) + longint'(py) * longint'($signed(m_step[63:32])));
    pty = longint'($signed(w));
    sx = longint'($signed(m_seed[31:0]));
    sy = longint'($signed(m_seed[63:32]));
    if (m_mode == efp_pkg::MODE_JULIA) cnt = escape_iters(ptx, pty, sx, sy, int'(m_max_iter));
    else cnt = escape_iters(sx, sy, ptx, pty, int'(m_max_iter));
    if (m_max_iter == 0) t = 65536;
    else t = (longint'(cnt) << 16) / longint'(m_max_iter);
    n = (m_pal_count > 4) ? 4 : int'(m_pal_count);
    r = '0;
    r.escape_count = cnt[efp_pkg::ITER_W-1:0];
    if (n >= 2) begin
      for (int k = 0; k < n; k++) begin
        col = (k < 2) ? m_pal_lo[24*k +: 24] : m_pal_hi[24*(k-2) +: 24];
        for (int c = 0; c < 3; c++) pts[k][c] = longint'(col[16 - 8*c +: 8]) << 16;
      end
      // de casteljau, one lerp level at a time
      for (int lvl = n - 1; lvl >= 1; lvl--)
        for (int k = 0; k < lvl; k++)
          for (int c = 0; c < 3; c++)
            pts[k][c] = pts[k][c] + (((pts[k+1][c] - pts[k][c]) * t) >>> 16);
      r.red   = pts[0][0][23:16];
      r.green = pts[0][1][23:16];
      r.blue  = pts[0][2][23:16];
    end
    return r;
  endfunction

  // mirror update follows the block's own masking
  task automatic write_reg(logic [efp_pkg::CFG_IDX_W-1:0] idx,
                           logic [efp_pkg::CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      efp_pkg::REG_MODE:      m_mode = data[0];
      efp_pkg::REG_ORIGIN:    m_origin = data;
      efp_pkg::REG_STEP:      m_step = data;
      efp_pkg::REG_SEED:      m_seed = data;
      efp_pkg::REG_MAX_ITER:  m_max_iter = data[efp_pkg::ITER_W-1:0];
      efp_pkg::REG_PAL_COUNT: m_pal_count = data[efp_pkg::PCNT_W-1:0];
      efp_pkg::REG_PAL_LO:    m_pal_lo = data[efp_pkg::PAL_W-1:0];
      efp_pkg::REG_PAL_HI:    m_pal_hi = data[efp_pkg::PAL_W-1:0];
      default: ;
    endcase
  endtask

  // drop valid, let every pending pixel drain, then settle
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pixel_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // one input beat; entered and left at a falling edge with nothing driven yet
  task automatic send_pixel(logic [efp_pkg::PIX_W-1:0] px, logic [efp_pkg::PIX_W-1:0] py,
                            logic known, shade_t want);
    shade_t e;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_if.valid <= 1'b1;
    in_if.pixel_x <= px;
    in_if.pixel_y <= py;
    do @(posedge clk); while (!in_if.ready);
    e = shade_pixel(px, py);
    if (known && e !== want)
      $display("note: typed expectation differs from prediction for pixel %0d,%0d", px, py);
    pixel_due.push_back(known ? want : e);
    pixels_sent++;
    if (m_mode == efp_pkg::MODE_JULIA) julia_pixels++;
    if (e.escape_count != m_max_iter) escaped_pixels++;
    burst_left--;
    @(negedge clk);
  endtask

  // result side: the stall style is redrawn at random from four styles
  int stall_style = 0;
  always @(negedge clk) begin
    if (cycle_count % 256 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 1) == 1);
      2: out_if.ready <= (cycle_count % 5 == 0);
      default: out_if.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // check each result beat against the oldest prediction
  always @(posedge clk) begin
    shade_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.red, out_if.green, out_if.blue, out_if.escape_count};
      pixels_seen++;
      if (pixel_due.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pixel_due.pop_front();
        if (got !== want) begin
          bad_pixels++;
          if (bad_pixels <= 10)
            $display("mismatch beat %0d: expected rgb %h%h%h iter %0d, got rgb %h%h%h iter %0d",
                     pixels_seen, want.red, want.green, want.blue, want.escape_count,
                     got.red, got.green, got.blue, got.escape_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  dir_row_t dir_tab[$];

  // random signed q4.28 value in [-span, span)
  function automatic logic [31:0] q_rand(int unsigned span);
    return 32'($urandom_range(0, 2 * span - 1)) - 32'(span);
  endfunction

  initial begin
    dir_row_t row;
    logic [31:0] st;
    shade_t none;
    in_if.valid = 1'b0;
    in_if.pixel_x = '0;
    in_if.pixel_y = '0;
    out_if.ready = 1'b0;
    m_mode = efp_pkg::MODE_MANDEL;
    m_origin = '0;
    m_step = '0;
    m_seed = '0;
    m_max_iter = efp_pkg::MAX_ITER_RST;
    m_pal_count = '0;
    m_pal_lo = '0;
    m_pal_hi = '0;
    none = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: c = 0 never escapes, no palette gives black
    dir_tab.push_back('{1'b0, efp_pkg::REG_MODE, 64'd0, 12'd0, 12'd0, 1'b1, '{0, 0, 0, 256}});
    dir_tab.push_back('{1'b0, efp_pkg::REG_MODE, 64'd0, 12'hFFF, 12'hFFF, 1'b1,
                        '{0, 0, 0, 256}});
    // max_iter zero: no iteration, t taken as one
    dir_tab.push_back('{1'b1, efp_pkg::REG_MAX_ITER, 64'd0, 12'd0, 12'd0, 1'b1,
                        '{0, 0, 0, 0}});
    dir_tab.push_back('{1'b1, efp_pkg::REG_PAL_LO, 64'hFFFFFF_000000, 12'd5, 12'd9, 1'b0,
                        none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_PAL_COUNT, 64'd2, 12'd0, 12'd0, 1'b1,
                        '{8'hFF, 8'hFF, 8'hFF, 0}});
    // point at 3.0 escapes on the first iteration, t zero picks colour 0
    dir_tab.push_back('{1'b1, efp_pkg::REG_MAX_ITER, 64'd1, 12'd0, 12'd0, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_ORIGIN, {32'd0, 32'h3000_0000}, 12'd0, 12'd0,
                        1'b1, '{0, 0, 0, 0}});
    // ignored register index
    dir_tab.push_back('{1'b1, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 12'd0, 1'b1,
                        '{0, 0, 0, 0}});
    // point wrap with the largest steps and pixels
    dir_tab.push_back('{1'b1, efp_pkg::REG_MAX_ITER, 64'd40, 12'hFFF, 12'hFFF, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_STEP, 64'h8000_0000_7FFF_FFFF, 12'hFFF, 12'hFFF,
                        1'b0, none});
    dir_tab.push_back('{1'b0, efp_pkg::REG_MODE, 64'd0, 12'hFFF, 12'd0, 1'b0, none});
    dir_tab.push_back('{1'b0, efp_pkg::REG_MODE, 64'd0, 12'd1, 12'hFFF, 1'b0, none});
    // julia with a classic seed over a small view
    dir_tab.push_back('{1'b1, efp_pkg::REG_ORIGIN, {32'hE800_0000, 32'hE800_0000}, 12'd0,
                        12'd0, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_STEP, {32'h0010_0000, 32'h0010_0000}, 12'd20,
                        12'd20, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_SEED, {32'h0AE1_47AE, 32'hF533_3333}, 12'd24,
                        12'd24, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_MODE, {63'd0, efp_pkg::MODE_JULIA}, 12'd24, 12'd24,
                        1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_PAL_HI, 64'h123456_89ABCD, 12'd10, 12'd40, 1'b0,
                        none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_PAL_COUNT, 64'd3, 12'd30, 12'd2, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_PAL_COUNT, 64'd4, 12'd30, 12'd2, 1'b0, none});
    // count above the slot number is clamped
    dir_tab.push_back('{1'b1, efp_pkg::REG_PAL_COUNT, 64'd7, 12'd17, 12'd31, 1'b0, none});
    // most negative seed escapes at once
    dir_tab.push_back('{1'b1, efp_pkg::REG_SEED, 64'h8000_0000_8000_0000, 12'd3, 12'd3, 1'b0,
                        none});
    // full depth max_iter, with a point that escapes at once
    dir_tab.push_back('{1'b1, efp_pkg::REG_MAX_ITER, 64'd65535, 12'd0, 12'd0, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_MODE, {63'd0, efp_pkg::MODE_MANDEL}, 12'd0, 12'd0,
                        1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_SEED, 64'd0, 12'd0, 12'd0, 1'b0, none});
    dir_tab.push_back('{1'b1, efp_pkg::REG_STEP, 64'd0, 12'hABC, 12'h543, 1'b0, none});

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.do_write) begin
        drain();
        write_reg(row.idx, row.data);
      end
      send_pixel(row.px, row.py, row.known, row.want);
    end

    // random phases: every register rewritten, mostly sensible views, some noise
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      if (ph % 5 == 4) begin
        write_reg(efp_pkg::REG_ORIGIN, {$urandom, $urandom});
        write_reg(efp_pkg::REG_STEP, {$urandom, $urandom});
        write_reg(efp_pkg::REG_SEED, {$urandom, $urandom});
      end else begin
        // view of about 4 units across the whole pixel range, zoomed at times
        write_reg(efp_pkg::REG_ORIGIN,
                  {q_rand(32'h1800_0000), q_rand(32'h2800_0000) - 32'h0800_0000});
        st = 32'h0004_0000 >> $urandom_range(0, 3);
        write_reg(efp_pkg::REG_STEP, {st, st});
        if ($urandom_range(0, 1) == 1)
          write_reg(efp_pkg::REG_SEED, {q_rand(Q_ONE), q_rand(Q_ONE)});
        else
          write_reg(efp_pkg::REG_SEED, {q_rand(Q_ONE >> 2), q_rand(Q_ONE >> 2)});
      end
      write_reg(efp_pkg::REG_MODE, {63'd0, ph[0]});
      case (ph)
        3:       write_reg(efp_pkg::REG_MAX_ITER, 64'd256);
        7:       write_reg(efp_pkg::REG_MAX_ITER, 64'($urandom_range(100, 400)));
        default: write_reg(efp_pkg::REG_MAX_ITER, 64'($urandom_range(1, 64)));
      endcase
      write_reg(efp_pkg::REG_PAL_COUNT, 64'($urandom_range(0, 7)));
      write_reg(efp_pkg::REG_PAL_LO, {16'd0, 16'($urandom_range(0, 65535)), $urandom});
      write_reg(efp_pkg::REG_PAL_HI, {16'd0, 16'($urandom_range(0, 65535)), $urandom});
      for (int i = 0; i < N_RANDOM / N_PHASES; i++)
        send_pixel(efp_pkg::PIX_W'($urandom_range(0, 4095)),
                   efp_pkg::PIX_W'($urandom_range(0, 4095)), 1'b0, none);
    end

    drain();
    $display("covered %0d pixels (%0d julia, %0d escaped) over %0d random setups",
             pixels_sent, julia_pixels, escaped_pixels, N_PHASES);
    $display("results checked %0d, mismatches %0d, cycles %0d",
             pixels_seen, bad_pixels, cycle_count);
    if (bad_pixels == 0 && pixel_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
